@@ hdl/mffs_pkg.sv @@
// Shared types, constants and helper functions for the mesh face fan flat shader.
`default_nettype none
package mffs_pkg;

  // Default store and face sizes.
  localparam int unsigned MAX_VERTICES_DEF = 4096;
  localparam int unsigned MAX_NORMALS_DEF  = 4096;
  localparam int unsigned MAX_CORNERS_DEF  = 128;

  // Fixed field widths.
  localparam int CC_W  = 8;
  localparam int REF_W = 14;

  // Reset face colour (0.7 in each channel) and shading terms in Q2.30.
  localparam logic [15:0] GRAY_07    = 16'd45875;
  localparam logic [31:0] SHADE_BASE = 32'd375809638;
  localparam logic [31:0] SHADE_GAIN = 32'd697932186;
  localparam logic [30:0] ONE_Q30    = 31'h4000_0000;

  // Bit-by-bit integer square root, used for elaboration constants only.
  function automatic logic [63:0] isqrt64(input logic [63:0] v);
    logic [63:0] x;
    logic [63:0] r;
    logic [63:0] b;
    x = v;
    r = '0;
    b = 64'h4000_0000_0000_0000;
    for (int i = 0; i < 32; i++) begin
      if (x >= r + b) begin
        x = x - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  // Light direction (30, 15, 94) normalized, in Q2.30.
  localparam logic [63:0] LIGHT_S   = isqrt64(64'd9961 << 40);
  localparam logic [63:0] LIGHT_X_W = (64'd30 << 50) / LIGHT_S;
  localparam logic [63:0] LIGHT_Y_W = (64'd15 << 50) / LIGHT_S;
  localparam logic [63:0] LIGHT_Z_W = (64'd94 << 50) / LIGHT_S;
  localparam logic [30:0] LIGHT_X   = LIGHT_X_W[30:0];
  localparam logic [30:0] LIGHT_Y   = LIGHT_Y_W[30:0];
  localparam logic [30:0] LIGHT_Z   = LIGHT_Z_W[30:0];

  typedef enum logic [1:0] {
    MODE_VERTEX,
    MODE_NORMAL,
    MODE_COLOUR,
    MODE_CORNER
  } item_mode_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_VRD,
    ST_VCAP,
    ST_NRD,
    ST_NCAP,
    ST_U_GO,
    ST_U_WAIT,
    ST_V_GO,
    ST_V_WAIT,
    ST_W_GO,
    ST_W_WAIT,
    ST_MAC,
    ST_SQ_GO,
    ST_SQ_WAIT,
    ST_OUT
  } seq_state_t;

  typedef enum logic [3:0] {
    JOB_CROSS0,
    JOB_CROSS1,
    JOB_CROSS2,
    JOB_DOT,
    JOB_NORM,
    JOB_SHADE,
    JOB_COL0,
    JOB_COL1,
    JOB_COL2
  } mac_job_t;

  typedef enum logic [1:0] {
    SQD_IDLE,
    SQD_ROOT,
    SQD_DIV,
    SQD_DONE
  } sqd_state_t;

  // Control word for the multiply-accumulate unit.
  typedef struct packed {
    logic go;
    logic clr;
    logic neg;
  } mac_ctl_t;

  typedef logic [2:0][63:0] wide_vec_t;
  typedef logic [2:0][30:0] blk_vec_t;

endpackage
`default_nettype wire

@@ hdl/mffs_in_if.sv @@
// Input channel interface: one mesh item per transaction.
`default_nettype none
interface mffs_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         mode;
  logic signed [31:0] x;
  logic signed [31:0] y;
  logic signed [31:0] z;
  logic [15:0]        red_in;
  logic [15:0]        green_in;
  logic [15:0]        blue_in;
  logic signed [13:0] vertex_ref;
  logic signed [13:0] normal_ref;
  logic               last_corner;

  modport source (output valid, mode, x, y, z, red_in, green_in, blue_in,
                  vertex_ref, normal_ref, last_corner, input ready);
  modport sink   (input valid, mode, x, y, z, red_in, green_in, blue_in,
                  vertex_ref, normal_ref, last_corner, output ready);
endinterface
`default_nettype wire

@@ hdl/mffs_out_if.sv @@
// Result channel interface: one shaded triangle per transaction.
`default_nettype none
interface mffs_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] ax;
  logic signed [31:0] ay;
  logic signed [31:0] az;
  logic signed [31:0] bx;
  logic signed [31:0] by;
  logic signed [31:0] bz;
  logic signed [31:0] cx;
  logic signed [31:0] cy;
  logic signed [31:0] cz;
  logic [15:0]        red_out;
  logic [15:0]        green_out;
  logic [15:0]        blue_out;

  modport source (output valid, ax, ay, az, bx, by, bz, cx, cy, cz,
                  red_out, green_out, blue_out, input ready);
  modport sink   (input valid, ax, ay, az, bx, by, bz, cx, cy, cz,
                  red_out, green_out, blue_out, output ready);
endinterface
`default_nettype wire

@@ hdl/mffs_ram.sv @@
// Simple dual-port store: one write port, one registered read port.
`default_nettype none
module mffs_ram #(
  parameter int DEPTH = mffs_pkg::MAX_VERTICES_DEF,
  parameter int WIDTH = 96
) (
  input  wire logic                     clk,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    rdata_o <= mem[raddr_i];
  end

endmodule
`default_nettype wire

@@ hdl/mffs_mac.sv @@
// Shared multiply-accumulate unit: registered product, then accumulate.
`default_nettype none
module mffs_mac (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire mffs_pkg::mac_ctl_t ctl_i,
  input  wire logic signed [31:0] a_i,
  input  wire logic signed [31:0] b_i,
  output logic signed [63:0]      acc_o
);

  mffs_pkg::mac_ctl_t ctl_r;
  logic signed [63:0] prod_r;
  logic signed [63:0] acc_r;

  // Control is registered alongside the product so that it lines up with the product register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r <= '0;
    end else begin
      ctl_r <= ctl_i;
    end
  end

  // Product register, then signed accumulate.
  always_ff @(posedge clk) begin
    prod_r <= a_i * b_i;
    if (ctl_r.go) begin
      acc_r <= (ctl_r.clr ? 64'sd0 : acc_r) + (ctl_r.neg ? -prod_r : prod_r);
    end
  end

  assign acc_o = acc_r;

endmodule
`default_nettype wire

@@ hdl/mffs_blkfmt.sv @@
// Block-form scaler: shifts three magnitudes so the largest lies in [2^29, 2^30).
`default_nettype none
module mffs_blkfmt (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                start_i,
  input  wire mffs_pkg::wide_vec_t vec_i,
  output logic                     done_o,
  output logic                     zero_o,
  output mffs_pkg::blk_vec_t       res_o
);

  logic              busy_r;
  logic [62:0]       m_r;
  logic [2:0][62:0]  mag_r;
  logic [2:0]        neg_r;
  logic [2:0][62:0]  mag_in;
  logic [2:0]        neg_in;
  logic [62:0]       m_in;
  logic              in_range;

  // Magnitudes and their maximum at start.
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      neg_in[i] = vec_i[i][63];
      mag_in[i] = neg_in[i] ? 63'(64'd0 - vec_i[i]) : vec_i[i][62:0];
    end
    m_in = mag_in[0];
    if (mag_in[1] > m_in) begin
      m_in = mag_in[1];
    end
    if (mag_in[2] > m_in) begin
      m_in = mag_in[2];
    end
  end

  assign in_range = (m_r[62:30] == '0) && m_r[29];
  assign zero_o   = (m_r == '0);
  assign done_o   = busy_r && (zero_o || in_range);

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      res_o[i] = neg_r[i] ? (31'd0 - mag_r[i][30:0]) : mag_r[i][30:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else if (start_i) begin
      busy_r <= 1'b1;
    end else if (done_o) begin
      busy_r <= 1'b0;
    end
  end

  // Coarse steps of eight bits, then single-bit steps toward the window.
  always_ff @(posedge clk) begin
    if (start_i) begin
      m_r   <= m_in;
      mag_r <= mag_in;
      neg_r <= neg_in;
    end else if (busy_r && !done_o) begin
      priority if (m_r[62:37] != '0) begin
        m_r <= m_r >> 8;
        for (int i = 0; i < 3; i++) mag_r[i] <= mag_r[i] >> 8;
      end else if (m_r[62:30] != '0) begin
        m_r <= m_r >> 1;
        for (int i = 0; i < 3; i++) mag_r[i] <= mag_r[i] >> 1;
      end else if (m_r[62:21] == '0) begin
        m_r <= m_r << 8;
        for (int i = 0; i < 3; i++) mag_r[i] <= mag_r[i] << 8;
      end else begin
        m_r <= m_r << 1;
        for (int i = 0; i < 3; i++) mag_r[i] <= mag_r[i] << 1;
      end
    end
  end

endmodule
`default_nettype wire

@@ hdl/mffs_sqdiv.sv @@
// Iterative square root then restoring division, one bit per cycle each.
`default_nettype none
module mffs_sqdiv (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start_i,
  input  wire logic [63:0] rad_i,
  input  wire logic [62:0] dvd_i,
  output logic             done_o,
  output logic [30:0]      q_o
);

  mffs_pkg::sqd_state_t st_r;
  mffs_pkg::sqd_state_t st_nxt;
  logic [63:0] x_r;
  logic [63:0] r_r;
  logic [63:0] b_r;
  logic [62:0] dvd_r;
  logic [30:0] p_r;
  logic [31:0] dl_r;
  logic [31:0] q_r;
  logic [4:0]  cnt_r;
  logic [63:0] rb_sum;
  logic [31:0] trial;

  assign rb_sum = r_r + b_r;
  assign trial  = {p_r, dl_r[31]};

  // Sequencer for root and quotient phases.
  always_comb begin
    st_nxt = st_r;
    done_o = 1'b0;
    unique case (st_r)
      mffs_pkg::SQD_IDLE: if (start_i) st_nxt = mffs_pkg::SQD_ROOT;
      mffs_pkg::SQD_ROOT: if (b_r == 64'd1) st_nxt = mffs_pkg::SQD_DIV;
      mffs_pkg::SQD_DIV:  if (cnt_r == 5'd31) st_nxt = mffs_pkg::SQD_DONE;
      mffs_pkg::SQD_DONE: begin
        done_o = 1'b1;
        st_nxt = mffs_pkg::SQD_IDLE;
      end
      default: st_nxt = mffs_pkg::SQD_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= mffs_pkg::SQD_IDLE;
    end else begin
      st_r <= st_nxt;
    end
  end

  // Datapath: root step, then one quotient bit per cycle.
  always_ff @(posedge clk) begin
    unique case (st_r)
      mffs_pkg::SQD_IDLE: begin
        x_r   <= rad_i;
        r_r   <= '0;
        b_r   <= 64'h4000_0000_0000_0000;
        dvd_r <= dvd_i;
        cnt_r <= '0;
      end
      mffs_pkg::SQD_ROOT: begin
        if (x_r >= rb_sum) begin
          x_r <= x_r - rb_sum;
          r_r <= (r_r >> 1) + b_r;
        end else begin
          r_r <= r_r >> 1;
        end
        b_r  <= b_r >> 2;
        p_r  <= dvd_r[62:32];
        dl_r <= dvd_r[31:0];
      end
      mffs_pkg::SQD_DIV: begin
        if (trial >= {1'b0, r_r[30:0]}) begin
          p_r  <= 31'(trial - {1'b0, r_r[30:0]});
          q_r  <= {q_r[30:0], 1'b1};
        end else begin
          p_r  <= trial[30:0];
          q_r  <= {q_r[30:0], 1'b0};
        end
        dl_r  <= dl_r << 1;
        cnt_r <= cnt_r + 5'd1;
      end
      default: begin
      end
    endcase
  end

  // Quotient saturates at one in Q2.30.
  assign q_o = (q_r > 32'(mffs_pkg::ONE_Q30)) ? mffs_pkg::ONE_Q30 : q_r[30:0];

endmodule
`default_nettype wire

@@ hdl/mesh_face_fan_flat_shader_top.sv @@
// Top level: item decode, vertex and normal stores, triangle sequencer and shading.
// Vertex, normal, colour, non-emitting and skipped corner items are taken without leaving idle.
// An emitting corner runs the triangle sequence until its result is offered; when the chosen
// direction is zero, the dot product, norm, square root and division steps are skipped.
// One item is in work at a time; ready is low from triangle start until its result is taken.
// Synchronous reset clears counts, face state and colour (0.7 gray); stores are not cleared.
`default_nettype none
module mesh_face_fan_flat_shader_top #(
  parameter int MAX_VERTICES = mffs_pkg::MAX_VERTICES_DEF,
  parameter int MAX_NORMALS  = mffs_pkg::MAX_NORMALS_DEF,
  parameter int MAX_CORNERS  = mffs_pkg::MAX_CORNERS_DEF
) (
  input wire logic    clk,
  input wire logic    rst_n,
  mffs_in_if.sink     in_ch,
  mffs_out_if.source  out_ch
);

  localparam int VAW = $clog2(MAX_VERTICES);
  localparam int NAW = $clog2(MAX_NORMALS);
  localparam int VCW = $clog2(MAX_VERTICES + 1);
  localparam int NCW = $clog2(MAX_NORMALS + 1);
  localparam int VSW = ((VCW + 1 > mffs_pkg::REF_W) ? VCW + 1 : mffs_pkg::REF_W) + 1;
  localparam int NSW = ((NCW + 1 > mffs_pkg::REF_W) ? NCW + 1 : mffs_pkg::REF_W) + 1;

  mffs_pkg::seq_state_t state_r, state_nxt;
  mffs_pkg::mac_job_t   job_r, job_nxt;
  logic [2:0]           stp_r, stp_nxt;
  logic [1:0]           idx_r, idx_nxt;

  logic [VCW-1:0]           vcnt_r;
  logic [NCW-1:0]           ncnt_r;
  logic [2:0][15:0]         col_r;
  logic [mffs_pkg::CC_W-1:0] cc_r;
  logic signed [VSW-1:0]    fvs_r, pvs_r;
  logic signed [NSW-1:0]    fns_r, pns_r;

  logic [VAW-1:0] tv_r [3];
  logic [NAW-1:0] tn_r [3];
  logic           alln_r;
  logic [95:0]    p_r [3];
  mffs_pkg::wide_vec_t vec_r;
  mffs_pkg::blk_vec_t  u_r, v_r, w_r;
  logic [63:0]    nn_r;
  logic signed [63:0] d_r;
  logic [30:0]    rq_r;
  logic [31:0]    shade_r;
  logic [2:0][15:0] ocol_r;

  logic in_ready, in_acc, out_valid;
  logic signed [VSW-1:0] vs_now;
  logic signed [NSW-1:0] ns_now;
  logic vs_ok_f, vs_ok_p, vs_ok_c;
  logic ns_ok_f, ns_ok_p, ns_ok_c;
  logic is_corner, corner_take, tri_go;
  logic v_we, n_we;
  logic [95:0] v_rdata, n_rdata;

  mffs_pkg::mac_ctl_t  mac_ctl;
  logic signed [31:0]  mac_a, mac_b;
  logic signed [63:0]  mac_acc;
  logic [2:0]          nops;

  logic                blk_start, blk_done, blk_zero;
  mffs_pkg::wide_vec_t blk_in;
  mffs_pkg::blk_vec_t  blk_res;

  logic        sq_start, sq_done;
  logic [30:0] sq_q;
  logic [62:0] ad;

  logic [63:0] col_rnd;
  logic [15:0] col_sat;

  // Slot resolution of the corner references against the current counts.
  always_comb begin
    if (in_ch.vertex_ref > 0) begin
      vs_now = VSW'(in_ch.vertex_ref) - VSW'(1);
    end else begin
      vs_now = $signed(VSW'(vcnt_r)) + VSW'(in_ch.vertex_ref);
    end
    if (in_ch.normal_ref == '0) begin
      ns_now = '1;
    end else if (in_ch.normal_ref > 0) begin
      ns_now = NSW'(in_ch.normal_ref) - NSW'(1);
    end else begin
      ns_now = $signed(NSW'(ncnt_r)) + NSW'(in_ch.normal_ref);
    end
  end

  assign vs_ok_f = !fvs_r[VSW-1] && ($unsigned(fvs_r) < VSW'(vcnt_r));
  assign vs_ok_p = !pvs_r[VSW-1] && ($unsigned(pvs_r) < VSW'(vcnt_r));
  assign vs_ok_c = !vs_now[VSW-1] && ($unsigned(vs_now) < VSW'(vcnt_r));
  assign ns_ok_f = !fns_r[NSW-1] && ($unsigned(fns_r) < NSW'(ncnt_r));
  assign ns_ok_p = !pns_r[NSW-1] && ($unsigned(pns_r) < NSW'(ncnt_r));
  assign ns_ok_c = !ns_now[NSW-1] && ($unsigned(ns_now) < NSW'(ncnt_r));

  assign in_acc      = in_ch.valid && in_ready;
  assign is_corner   = (in_ch.mode == mffs_pkg::MODE_CORNER);
  assign corner_take = in_acc && is_corner && (cc_r < mffs_pkg::CC_W'(MAX_CORNERS));
  assign tri_go      = corner_take && (cc_r >= mffs_pkg::CC_W'(2))
                       && vs_ok_f && vs_ok_p && vs_ok_c;
  assign v_we = in_acc && (in_ch.mode == mffs_pkg::MODE_VERTEX)
                && (vcnt_r < VCW'(MAX_VERTICES));
  assign n_we = in_acc && (in_ch.mode == mffs_pkg::MODE_NORMAL)
                && (ncnt_r < NCW'(MAX_NORMALS));

  // Vertex and normal stores.
  mffs_ram #(.DEPTH(MAX_VERTICES), .WIDTH(96)) u_vstore (
    .clk     (clk),
    .we_i    (v_we),
    .waddr_i (vcnt_r[VAW-1:0]),
    .wdata_i ({in_ch.x, in_ch.y, in_ch.z}),
    .raddr_i (tv_r[idx_r]),
    .rdata_o (v_rdata)
  );

  mffs_ram #(.DEPTH(MAX_NORMALS), .WIDTH(96)) u_nstore (
    .clk     (clk),
    .we_i    (n_we),
    .waddr_i (ncnt_r[NAW-1:0]),
    .wdata_i ({in_ch.x, in_ch.y, in_ch.z}),
    .raddr_i (tn_r[idx_r]),
    .rdata_o (n_rdata)
  );

  // Number of products per accumulation job.
  always_comb begin
    unique case (job_r)
      mffs_pkg::JOB_CROSS0, mffs_pkg::JOB_CROSS1, mffs_pkg::JOB_CROSS2: nops = 3'd2;
      mffs_pkg::JOB_DOT, mffs_pkg::JOB_NORM:                             nops = 3'd3;
      default:                                                           nops = 3'd1;
    endcase
  end

  // Sequencer: next state and control outputs.
  always_comb begin
    state_nxt = state_r;
    job_nxt   = job_r;
    stp_nxt   = stp_r;
    idx_nxt   = idx_r;
    in_ready  = 1'b0;
    out_valid = 1'b0;
    blk_start = 1'b0;
    sq_start  = 1'b0;
    mac_ctl   = '0;
    unique case (state_r)
      mffs_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (tri_go) begin
          state_nxt = mffs_pkg::ST_VRD;
          idx_nxt   = '0;
        end
      end
      mffs_pkg::ST_VRD: state_nxt = mffs_pkg::ST_VCAP;
      mffs_pkg::ST_VCAP: begin
        if (idx_r == 2'd2) begin
          idx_nxt   = '0;
          state_nxt = alln_r ? mffs_pkg::ST_NRD : mffs_pkg::ST_U_GO;
        end else begin
          idx_nxt   = idx_r + 2'd1;
          state_nxt = mffs_pkg::ST_VRD;
        end
      end
      mffs_pkg::ST_NRD: state_nxt = mffs_pkg::ST_NCAP;
      mffs_pkg::ST_NCAP: begin
        if (idx_r == 2'd2) begin
          idx_nxt   = '0;
          state_nxt = mffs_pkg::ST_W_GO;
        end else begin
          idx_nxt   = idx_r + 2'd1;
          state_nxt = mffs_pkg::ST_NRD;
        end
      end
      mffs_pkg::ST_U_GO: begin
        blk_start = 1'b1;
        state_nxt = mffs_pkg::ST_U_WAIT;
      end
      mffs_pkg::ST_U_WAIT: if (blk_done) state_nxt = mffs_pkg::ST_V_GO;
      mffs_pkg::ST_V_GO: begin
        blk_start = 1'b1;
        state_nxt = mffs_pkg::ST_V_WAIT;
      end
      mffs_pkg::ST_V_WAIT: begin
        if (blk_done) begin
          state_nxt = mffs_pkg::ST_MAC;
          job_nxt   = mffs_pkg::JOB_CROSS0;
          stp_nxt   = '0;
        end
      end
      mffs_pkg::ST_W_GO: begin
        blk_start = 1'b1;
        state_nxt = mffs_pkg::ST_W_WAIT;
      end
      mffs_pkg::ST_W_WAIT: begin
        if (blk_done) begin
          state_nxt = mffs_pkg::ST_MAC;
          job_nxt   = blk_zero ? mffs_pkg::JOB_SHADE : mffs_pkg::JOB_DOT;
          stp_nxt   = '0;
        end
      end
      mffs_pkg::ST_MAC: begin
        mac_ctl.go  = (stp_r < nops);
        mac_ctl.clr = (stp_r == 3'd0);
        mac_ctl.neg = (stp_r == 3'd1) && (job_r == mffs_pkg::JOB_CROSS0
                      || job_r == mffs_pkg::JOB_CROSS1 || job_r == mffs_pkg::JOB_CROSS2);
        if (stp_r == nops + 3'd1) begin
          stp_nxt = '0;
          unique case (job_r)
            mffs_pkg::JOB_CROSS0: job_nxt = mffs_pkg::JOB_CROSS1;
            mffs_pkg::JOB_CROSS1: job_nxt = mffs_pkg::JOB_CROSS2;
            mffs_pkg::JOB_CROSS2: state_nxt = mffs_pkg::ST_W_GO;
            mffs_pkg::JOB_DOT:    job_nxt = mffs_pkg::JOB_NORM;
            mffs_pkg::JOB_NORM:   state_nxt = mffs_pkg::ST_SQ_GO;
            mffs_pkg::JOB_SHADE:  job_nxt = mffs_pkg::JOB_COL0;
            mffs_pkg::JOB_COL0:   job_nxt = mffs_pkg::JOB_COL1;
            mffs_pkg::JOB_COL1:   job_nxt = mffs_pkg::JOB_COL2;
            mffs_pkg::JOB_COL2:   state_nxt = mffs_pkg::ST_OUT;
            default:              state_nxt = mffs_pkg::ST_IDLE;
          endcase
        end else begin
          stp_nxt = stp_r + 3'd1;
        end
      end
      mffs_pkg::ST_SQ_GO: begin
        sq_start  = 1'b1;
        state_nxt = mffs_pkg::ST_SQ_WAIT;
      end
      mffs_pkg::ST_SQ_WAIT: begin
        if (sq_done) begin
          state_nxt = mffs_pkg::ST_MAC;
          job_nxt   = mffs_pkg::JOB_SHADE;
          stp_nxt   = '0;
        end
      end
      mffs_pkg::ST_OUT: begin
        out_valid = 1'b1;
        if (out_ch.ready) state_nxt = mffs_pkg::ST_IDLE;
      end
      default: state_nxt = mffs_pkg::ST_IDLE;
    endcase
  end

  // Operand selection for the shared multiplier.
  always_comb begin
    mac_a = '0;
    mac_b = '0;
    unique case (job_r)
      mffs_pkg::JOB_CROSS0: begin
        mac_a = 32'($signed(stp_r[0] ? u_r[2] : u_r[1]));
        mac_b = 32'($signed(stp_r[0] ? v_r[1] : v_r[2]));
      end
      mffs_pkg::JOB_CROSS1: begin
        mac_a = 32'($signed(stp_r[0] ? u_r[0] : u_r[2]));
        mac_b = 32'($signed(stp_r[0] ? v_r[2] : v_r[0]));
      end
      mffs_pkg::JOB_CROSS2: begin
        mac_a = 32'($signed(stp_r[0] ? u_r[1] : u_r[0]));
        mac_b = 32'($signed(stp_r[0] ? v_r[0] : v_r[1]));
      end
      mffs_pkg::JOB_DOT: begin
        priority if (stp_r == 3'd0) begin
          mac_a = 32'($signed(w_r[0]));
          mac_b = 32'(mffs_pkg::LIGHT_X);
        end else if (stp_r == 3'd1) begin
          mac_a = 32'($signed(w_r[1]));
          mac_b = 32'(mffs_pkg::LIGHT_Y);
        end else begin
          mac_a = 32'($signed(w_r[2]));
          mac_b = 32'(mffs_pkg::LIGHT_Z);
        end
      end
      mffs_pkg::JOB_NORM: begin
        priority if (stp_r == 3'd0) begin
          mac_a = 32'($signed(w_r[0]));
          mac_b = 32'($signed(w_r[0]));
        end else if (stp_r == 3'd1) begin
          mac_a = 32'($signed(w_r[1]));
          mac_b = 32'($signed(w_r[1]));
        end else begin
          mac_a = 32'($signed(w_r[2]));
          mac_b = 32'($signed(w_r[2]));
        end
      end
      mffs_pkg::JOB_SHADE: begin
        mac_a = mffs_pkg::SHADE_GAIN;
        mac_b = 32'(rq_r);
      end
      mffs_pkg::JOB_COL0: begin
        mac_a = 32'(col_r[0]);
        mac_b = shade_r;
      end
      mffs_pkg::JOB_COL1: begin
        mac_a = 32'(col_r[1]);
        mac_b = shade_r;
      end
      mffs_pkg::JOB_COL2: begin
        mac_a = 32'(col_r[2]);
        mac_b = shade_r;
      end
      default: begin
      end
    endcase
  end

  mffs_mac u_mac (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl_i (mac_ctl),
    .a_i   (mac_a),
    .b_i   (mac_b),
    .acc_o (mac_acc)
  );

  // Block-form input: edge vectors or the chosen normal vector.
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      unique case (state_r)
        mffs_pkg::ST_U_GO: blk_in[i] = 64'($signed(p_r[1][(2-i)*32 +: 32]))
                                     - 64'($signed(p_r[0][(2-i)*32 +: 32]));
        mffs_pkg::ST_V_GO: blk_in[i] = 64'($signed(p_r[2][(2-i)*32 +: 32]))
                                     - 64'($signed(p_r[0][(2-i)*32 +: 32]));
        default:           blk_in[i] = vec_r[i];
      endcase
    end
  end

  mffs_blkfmt u_blkfmt (
    .clk     (clk),
    .rst_n   (rst_n),
    .start_i (blk_start),
    .vec_i   (blk_in),
    .done_o  (blk_done),
    .zero_o  (blk_zero),
    .res_o   (blk_res)
  );

  assign ad = d_r[63] ? 63'(64'd0 - d_r) : d_r[62:0];

  mffs_sqdiv u_sqdiv (
    .clk     (clk),
    .rst_n   (rst_n),
    .start_i (sq_start),
    .rad_i   (nn_r),
    .dvd_i   (ad),
    .done_o  (sq_done),
    .q_o     (sq_q)
  );

  // Rounded and saturated colour channel from the accumulator.
  assign col_rnd = mac_acc + 64'h2000_0000;
  assign col_sat = (col_rnd[47:46] != 2'b00) ? 16'hFFFF : col_rnd[45:30];

  // Control state and counts.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= mffs_pkg::ST_IDLE;
      job_r   <= mffs_pkg::JOB_CROSS0;
      stp_r   <= '0;
      idx_r   <= '0;
      vcnt_r  <= '0;
      ncnt_r  <= '0;
      col_r   <= {3{mffs_pkg::GRAY_07}};
      cc_r    <= '0;
      fvs_r   <= '0;
      pvs_r   <= '0;
      fns_r   <= '1;
      pns_r   <= '1;
    end else begin
      state_r <= state_nxt;
      job_r   <= job_nxt;
      stp_r   <= stp_nxt;
      idx_r   <= idx_nxt;
      if (v_we) vcnt_r <= vcnt_r + VCW'(1);
      if (n_we) ncnt_r <= ncnt_r + NCW'(1);
      if (in_acc && (in_ch.mode == mffs_pkg::MODE_COLOUR)) begin
        col_r <= {in_ch.blue_in, in_ch.green_in, in_ch.red_in};
      end
      if (corner_take) begin
        if (cc_r == '0) begin
          fvs_r <= vs_now;
          fns_r <= ns_now;
        end
        pvs_r <= vs_now;
        pns_r <= ns_now;
      end
      // A closing corner ends the face even when it lies past the cap.
      if (in_acc && is_corner && in_ch.last_corner) begin
        cc_r <= '0;
      end else if (corner_take) begin
        cc_r <= cc_r + mffs_pkg::CC_W'(1);
      end
    end
  end

  // Triangle datapath captures.
  always_ff @(posedge clk) begin
    if (tri_go) begin
      tv_r[0] <= fvs_r[VAW-1:0];
      tv_r[1] <= pvs_r[VAW-1:0];
      tv_r[2] <= vs_now[VAW-1:0];
      tn_r[0] <= fns_r[NAW-1:0];
      tn_r[1] <= pns_r[NAW-1:0];
      tn_r[2] <= ns_now[NAW-1:0];
      alln_r  <= ns_ok_f && ns_ok_p && ns_ok_c;
      vec_r   <= '0;
    end
    if (state_r == mffs_pkg::ST_VCAP) begin
      p_r[idx_r] <= v_rdata;
    end
    if (state_r == mffs_pkg::ST_NCAP) begin
      for (int i = 0; i < 3; i++) begin
        vec_r[i] <= vec_r[i] + 64'($signed(n_rdata[(2-i)*32 +: 32]));
      end
    end
    if (state_r == mffs_pkg::ST_U_WAIT && blk_done) u_r <= blk_res;
    if (state_r == mffs_pkg::ST_V_WAIT && blk_done) v_r <= blk_res;
    if (state_r == mffs_pkg::ST_W_WAIT && blk_done) begin
      w_r <= blk_res;
      if (blk_zero) rq_r <= mffs_pkg::LIGHT_Z;
    end
    if (state_r == mffs_pkg::ST_SQ_WAIT && sq_done) rq_r <= sq_q;
    if (state_r == mffs_pkg::ST_MAC && stp_r == nops + 3'd1) begin
      unique case (job_r)
        mffs_pkg::JOB_CROSS0: vec_r[0] <= mac_acc;
        mffs_pkg::JOB_CROSS1: vec_r[1] <= mac_acc;
        mffs_pkg::JOB_CROSS2: vec_r[2] <= mac_acc;
        mffs_pkg::JOB_DOT:    d_r      <= mac_acc;
        mffs_pkg::JOB_NORM:   nn_r     <= mac_acc;
        mffs_pkg::JOB_SHADE:  shade_r  <= mffs_pkg::SHADE_BASE + mac_acc[61:30];
        mffs_pkg::JOB_COL0:   ocol_r[0] <= col_sat;
        mffs_pkg::JOB_COL1:   ocol_r[1] <= col_sat;
        mffs_pkg::JOB_COL2:   ocol_r[2] <= col_sat;
        default: begin
        end
      endcase
    end
  end

  // Channel outputs.
  assign in_ch.ready      = in_ready;
  assign out_ch.valid     = out_valid;
  assign out_ch.ax        = p_r[0][95:64];
  assign out_ch.ay        = p_r[0][63:32];
  assign out_ch.az        = p_r[0][31:0];
  assign out_ch.bx        = p_r[1][95:64];
  assign out_ch.by        = p_r[1][63:32];
  assign out_ch.bz        = p_r[1][31:0];
  assign out_ch.cx        = p_r[2][95:64];
  assign out_ch.cy        = p_r[2][63:32];
  assign out_ch.cz        = p_r[2][31:0];
  assign out_ch.red_out   = ocol_r[0];
  assign out_ch.green_out = ocol_r[1];
  assign out_ch.blue_out  = ocol_r[2];

`ifndef SYNTH
  // The block never takes an item while a result is on offer.
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ch.ready && out_ch.valid))
    else $error("input ready while a result is pending");

  // Store counts stay within capacity.
  a_vcnt_cap: assert property (@(posedge clk) disable iff (!rst_n)
    (vcnt_r <= VCW'(MAX_VERTICES)) && (ncnt_r <= NCW'(MAX_NORMALS)))
    else $error("store count beyond capacity");

  // Corner count never passes the face limit.
  a_cc_cap: assert property (@(posedge clk) disable iff (!rst_n)
    cc_r <= mffs_pkg::CC_W'(MAX_CORNERS))
    else $error("corner count beyond limit");

  // A delivered result returns the block to accepting items.
  a_return: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.ready) |=> in_ch.ready)
    else $error("block not ready after result transaction");
`endif

endmodule
`default_nettype wire
